FILE: src/tta_pkg.sv
// Shared types, constants and helpers for the tick-to-bar aggregator.
// No dependencies; every other file imports this package.
package tta_pkg;

    localparam int MAX_LEVELS = 32;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);

    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [30:0] VOL_MAX     = '1;
    localparam logic [61:0] BAR_VOL_MAX = '1;
    localparam logic [30:0] SIZE_RESET  = 31'd60;

    localparam int FLAG_LEVEL = 0;
    localparam int FLAG_MARK  = 1;
    localparam int FLAG_OVF   = 2;

    typedef enum logic [0:0] {
        CFG_BAR_MODE = 1'b0,
        CFG_BAR_SIZE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_TIME   = 2'd0,
        MODE_RANGE  = 2'd1,
        MODE_VOLUME = 2'd2,
        MODE_NONE   = 2'd3
    } t_bar_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ACC,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_SPAN,
        S_ACC,
        S_POC,
        S_SUM,
        S_LVL
    } t_state;

    typedef struct packed {
        logic               func;
        logic [62:0]        time_ns;
        logic signed [31:0] price_ticks;
        logic [30:0]        trade_volume;
        logic               side_is_bid;
        logic               accumulatable;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         flags;
        logic               last_of_bar;
        logic signed [31:0] price_out;
        logic signed [31:0] high_out;
        logic signed [31:0] low_out;
        logic signed [31:0] close_out;
        logic signed [31:0] control_price;
        logic [61:0]        volume_out;
        logic [31:0]        ask_or_control_volume;
        logic [30:0]        bid_volume_out;
        logic [62:0]        open_time_out;
        logic [62:0]        close_time_out;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] price;
        logic [30:0]        ask;
        logic [30:0]        bid;
    } t_level;

    typedef struct packed {
        t_cell_op           op;
        logic               new_level;
        logic signed [31:0] price;
        logic [30:0]        volume;
        logic               side_is_bid;
    } t_cell_ctl;

    function automatic logic [30:0] sat_add31(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31] ? VOL_MAX : s[30:0];
    endfunction

endpackage

FILE: src/tta_cell.sv
// One price level of the sorted level chain: match, sorted insert and drain shift.
// Depends on tta_pkg.
module tta_cell (
    input  logic               i_clk,
    input  tta_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic               i_prev_gt,
    input  logic               i_at_end,
    input  tta_pkg::t_level    i_left,
    input  tta_pkg::t_level    i_right,
    output logic               o_gt,
    output logic               o_hit,
    output tta_pkg::t_level    o_level
);
    import tta_pkg::*;

    t_level r_level;
    t_level n_level;

    assign o_gt    = i_valid && ($signed(r_level.price) > $signed(i_ctl.price));
    assign o_hit   = i_valid && (r_level.price == i_ctl.price);
    assign o_level = r_level;

    always_comb begin
        n_level = r_level;
        unique case (i_ctl.op)
            CELL_ACC: begin
                if (i_ctl.new_level) begin
                    // Levels above the new price move one place up the chain.
                    if (i_prev_gt) begin
                        n_level = i_left;
                    end else if (o_gt || i_at_end) begin
                        n_level.price = i_ctl.price;
                        n_level.ask   = i_ctl.side_is_bid ? '0 : i_ctl.volume;
                        n_level.bid   = i_ctl.side_is_bid ? i_ctl.volume : '0;
                    end
                end else if (o_hit) begin
                    if (i_ctl.side_is_bid) begin
                        n_level.bid = sat_add31(r_level.bid, i_ctl.volume);
                    end else begin
                        n_level.ask = sat_add31(r_level.ask, i_ctl.volume);
                    end
                end
            end
            CELL_SHIFT: begin
                n_level = i_right;
            end
            default: begin
                n_level = r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

endmodule

FILE: src/tta_span.sv
// Time-bar boundary unit: span = size * 1e9, then a bit-serial remainder of the
// bar start by the span, giving end = start - rem + span. Depends on tta_pkg.
module tta_span (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_size,
    input  logic [62:0] i_base,
    output logic        o_busy,
    output logic [63:0] o_end
);
    import tta_pkg::*;

    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_cnt;
    logic [60:0] r_span;
    logic [60:0] r_rem;
    logic [62:0] r_base;
    logic [63:0] r_end;

    logic [30:0] w_size;
    logic [61:0] w_trial;
    logic [61:0] w_diff;
    logic        w_ge;

    assign w_size  = (i_size == '0) ? 31'd1 : i_size;
    assign w_trial = {r_rem, r_base[r_cnt]};
    assign w_ge    = w_trial >= {1'b0, r_span};
    assign w_diff  = w_trial - {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_fin  <= 1'b0;
        end else if (r_fin) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_fin <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_span <= {30'b0, w_size} * {31'b0, NS_PER_SEC};
            r_rem  <= '0;
            r_cnt  <= 6'd62;
            r_base <= i_base;
        end else if (r_busy && !r_fin) begin
            r_rem <= w_ge ? w_diff[60:0] : w_trial[60:0];
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
        if (r_fin) begin
            r_end <= {1'b0, r_base} - {3'b0, r_rem} + {3'b0, r_span};
        end
    end

    assign o_busy = r_busy;
    assign o_end  = r_end;

endmodule

FILE: src/tick_to_bar_aggregator.sv
// Top level: bar state, close test, chain of price-level cells and the output register.
// Depends on tta_pkg, tta_cell and tta_span.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  output  | out       | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A tick passes through accept, close test, level-chain update and point-of-control update.
// In time mode the first test after a bar opens or after a config write first waits
// for the serial remainder in tta_span.
// A closing bar then drains one word per cycle while the output is free: the summary and one word per level.
// Output stalls stall the drain only; a finished word waits in the output register.
// Reset is synchronous; the level chain needs no clearing.
module tick_to_bar_aggregator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tta_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tta_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  tta_pkg::t_cfg_idx   i_cfg_index,
    input  logic [30:0]         i_cfg_data
);
    import tta_pkg::*;

    t_state     r_state, n_state;
    t_bar_mode  r_mode;
    logic [30:0] r_size;
    t_in_word   r_in;
    logic       r_active, n_active;
    logic signed [31:0] r_open, n_open, r_high, n_high, r_low, n_low, r_last, n_last;
    logic [62:0] r_start, n_start;
    logic [61:0] r_bar_vol, n_bar_vol;
    logic [CNT_W-1:0] r_count, n_count;
    logic       r_ovf, n_ovf;
    logic signed [31:0] r_poc_price, n_poc_price;
    logic [31:0] r_poc_vol, n_poc_vol;
    logic       r_poc_ok, n_poc_ok;
    logic       r_closing, n_closing;
    logic       r_end_ok, n_end_ok;
    logic       r_out_valid;
    t_out_word  r_out, n_out;
    logic       w_load;
    logic       w_span_start;
    logic       w_span_busy;
    logic [63:0] w_span_end;

    t_cell_ctl  w_ctl;
    logic [MAX_LEVELS-1:0] w_gt;
    logic [MAX_LEVELS-1:0] w_hit;
    t_level     w_level [MAX_LEVELS];
    logic       w_any_hit;
    logic [31:0] w_hit_tot;
    logic       w_out_free;
    logic       w_close;
    logic [30:0] w_eff;
    logic signed [32:0] w_dist;
    logic [32:0] w_abs;
    logic [62:0] w_vol_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_any_hit   = |w_hit;

    // Level chain
    always_comb begin
        w_ctl.op          = (r_state == S_ACC) ? CELL_ACC :
                            ((r_state == S_LVL && w_out_free) ? CELL_SHIFT : CELL_HOLD);
        w_ctl.new_level   = !w_any_hit && (r_count < CNT_W'(MAX_LEVELS));
        w_ctl.price       = r_in.price_ticks;
        w_ctl.volume      = r_in.trade_volume;
        w_ctl.side_is_bid = r_in.side_is_bid;
    end

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_chain
        logic   w_prev_gt;
        t_level w_left;
        t_level w_right;
        if (g == 0) begin : g_first
            assign w_prev_gt = 1'b0;
            assign w_left    = w_level[g];
        end else begin : g_mid
            assign w_prev_gt = w_gt[g-1];
            assign w_left    = w_level[g-1];
        end
        if (g == MAX_LEVELS - 1) begin : g_last
            assign w_right = w_level[g];
        end else begin : g_inner
            assign w_right = w_level[g+1];
        end
        tta_cell u_level (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_valid   (CNT_W'(g) < r_count),
            .i_prev_gt (w_prev_gt),
            .i_at_end  (CNT_W'(g) == r_count),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_gt      (w_gt[g]),
            .o_hit     (w_hit[g]),
            .o_level   (w_level[g])
        );
    end

    always_comb begin
        w_hit_tot = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (w_hit[i]) begin
                w_hit_tot = w_hit_tot | ({1'b0, w_level[i].ask} + {1'b0, w_level[i].bid});
            end
        end
    end

    tta_span u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_span_start),
        .i_size  (r_size),
        .i_base  (r_start),
        .o_busy  (w_span_busy),
        .o_end   (w_span_end)
    );

    // Close test on the bar as it stood before the tick
    assign w_eff  = (r_size == '0) ? 31'd1 : r_size;
    assign w_dist = {r_in.price_ticks[31], r_in.price_ticks} - {r_open[31], r_open};
    assign w_abs  = w_dist[32] ? 33'(-w_dist) : 33'(w_dist);
    assign w_vol_sum = {1'b0, r_bar_vol} + {32'b0, r_in.trade_volume};

    always_comb begin
        unique case (r_mode)
            MODE_TIME:   w_close = {1'b0, r_in.time_ns} >= w_span_end;
            MODE_RANGE:  w_close = w_abs >= {2'b0, w_eff};
            MODE_VOLUME: w_close = r_bar_vol >= {31'b0, w_eff};
            MODE_NONE:   w_close = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_open      = r_open;
        n_high      = r_high;
        n_low       = r_low;
        n_last      = r_last;
        n_start     = r_start;
        n_bar_vol   = r_bar_vol;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_poc_price = r_poc_price;
        n_poc_vol   = r_poc_vol;
        n_poc_ok    = r_poc_ok;
        n_closing   = r_closing;
        n_end_ok    = r_end_ok;
        n_out       = r_out;
        w_load      = 1'b0;
        w_span_start = 1'b0;

        n_out.high_out       = r_high;
        n_out.low_out        = r_low;
        n_out.close_out      = r_last;
        n_out.control_price  = r_poc_price;
        n_out.open_time_out  = r_start;
        n_out.close_time_out = r_in.time_ns;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                priority if (r_in.func) begin
                    n_state = r_active ? S_SUM : S_IDLE;
                end else if (!r_in.accumulatable) begin
                    n_state = S_IDLE;
                end else if (!r_active) begin
                    n_active    = 1'b1;
                    n_open      = r_in.price_ticks;
                    n_high      = r_in.price_ticks;
                    n_low       = r_in.price_ticks;
                    n_last      = r_in.price_ticks;
                    n_start     = r_in.time_ns;
                    n_bar_vol   = '0;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_poc_price = '0;
                    n_poc_vol   = '0;
                    n_poc_ok    = 1'b0;
                    n_end_ok    = 1'b0;
                    n_closing   = 1'b0;
                    n_state     = S_ACC;
                end else if (r_mode == MODE_TIME && !r_end_ok) begin
                    w_span_start = 1'b1;
                    n_state      = S_SPAN;
                end else begin
                    n_closing = w_close;
                    n_state   = S_ACC;
                end
            end
            S_SPAN: begin
                if (!w_span_busy) begin
                    n_end_ok = 1'b1;
                    n_state  = S_TEST;
                end
            end
            S_ACC: begin
                if (w_ctl.new_level) begin
                    n_count = r_count + CNT_W'(1);
                end else if (!w_any_hit) begin
                    n_ovf = 1'b1;
                end
                n_bar_vol = w_vol_sum[62] ? BAR_VOL_MAX : w_vol_sum[61:0];
                if ($signed(r_in.price_ticks) > $signed(r_high)) begin
                    n_high = r_in.price_ticks;
                end
                if ($signed(r_in.price_ticks) < $signed(r_low)) begin
                    n_low = r_in.price_ticks;
                end
                n_last  = r_in.price_ticks;
                n_state = S_POC;
            end
            S_POC: begin
                // Level totals only grow, so the touched level is the only challenger.
                if (w_any_hit && (!r_poc_ok || w_hit_tot > r_poc_vol ||
                    (w_hit_tot == r_poc_vol &&
                     $signed(r_in.price_ticks) < $signed(r_poc_price)))) begin
                    n_poc_ok    = 1'b1;
                    n_poc_vol   = w_hit_tot;
                    n_poc_price = r_in.price_ticks;
                end
                n_state = r_closing ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_out.flags = '0;
                    n_out.flags[FLAG_OVF]  = r_ovf;
                    n_out.flags[FLAG_MARK] = $signed(r_last) > $signed(r_open);
                    n_out.last_of_bar           = (r_count == '0);
                    n_out.price_out             = r_open;
                    n_out.volume_out            = r_bar_vol;
                    n_out.ask_or_control_volume = r_poc_vol;
                    n_out.bid_volume_out        = '0;
                    if (r_count == '0) begin
                        n_active = 1'b0;
                        n_ovf    = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_LVL;
                    end
                end
            end
            S_LVL: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_out.flags = '0;
                    n_out.flags[FLAG_LEVEL] = 1'b1;
                    n_out.flags[FLAG_OVF]   = r_ovf;
                    n_out.flags[FLAG_MARK]  = (w_level[0].price == r_poc_price);
                    n_out.last_of_bar           = (r_count == CNT_W'(1));
                    n_out.price_out             = w_level[0].price;
                    n_out.volume_out            = 62'({1'b0, w_level[0].ask} +
                                                      {1'b0, w_level[0].bid});
                    n_out.ask_or_control_volume = {1'b0, w_level[0].ask};
                    n_out.bid_volume_out        = w_level[0].bid;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_active = 1'b0;
                        n_ovf    = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_TIME;
            r_size      <= SIZE_RESET;
            r_active    <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_poc_ok    <= 1'b0;
            r_closing   <= 1'b0;
            r_end_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_poc_ok  <= n_poc_ok;
            r_closing <= n_closing;
            // A new size or mode needs a fresh time boundary.
            r_end_ok  <= n_end_ok && !i_cfg_valid;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BAR_MODE: r_mode <= t_bar_mode'(i_cfg_data[1:0]);
                    CFG_BAR_SIZE: r_size <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
        r_open      <= n_open;
        r_high      <= n_high;
        r_low       <= n_low;
        r_last      <= n_last;
        r_start     <= n_start;
        r_bar_vol   <= n_bar_vol;
        r_poc_price <= n_poc_price;
        r_poc_vol   <= n_poc_vol;
        // The output word is held steady until the receiver takes it.
        if (w_load) begin
            r_out <= n_out;
        end
    end

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one level matches the tick price");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEVELS))
        else $error("level count beyond the chain length");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LVL) |-> (r_count != '0))
        else $error("level drain with an empty chain");

    a_span_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_span_busy)
        else $error("boundary unit busy while idle");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LVL && w_out_free && r_count == CNT_W'(1)) |=> !r_active)
        else $error("bar still open after its last level word");

endmodule
